// ----- design/mrp_pkg.sv -----
// Shared constants, types and CRC function for the Modbus read-response parser.
package mrp_pkg;

  localparam int          MAX_REGS_DEFAULT  = 8;
  localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h0A;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  // Register count field, wide enough for the largest register list (125)
  localparam int          CNT_W             = 7;

  // One accepted frame waiting to be emitted
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
  } frame_desc_t;

  // Back side hands a store bank back to the parser
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // Register store write strobe and word
  typedef struct packed {
    logic        en;
    logic [15:0] data;
  } store_wr_t;

  // Modbus CRC-16 update over one byte, reflected polynomial
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/mrp_front.sv -----
// Byte parser: hunts the frame header, runs the CRC and fills the register store.
module mrp_front #(
  parameter int MAX_REGS = 8,
  parameter int IDX_W    = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           slave_address,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,     // rx_byte[7:0]
  output mrp_pkg::store_wr_t   wr,
  output logic [IDX_W:0]       wr_addr,
  output logic                 desc_valid,
  input  logic                 desc_ready,
  output mrp_pkg::frame_desc_t desc,
  input  mrp_pkg::release_t    rel
);
  import mrp_pkg::*;

  localparam int WI_W = $clog2(MAX_REGS + 1);
  localparam logic [8:0] MaxBytes = 9'(2 * MAX_REGS);

  typedef enum logic [2:0] {
    PH_HUNT, PH_FUNC, PH_COUNT, PH_HIGH, PH_LOW, PH_CRC_LO, PH_CRC_HI
  } phase_t;

  phase_t          phase;
  logic [7:0]      byte_count;
  logic [WI_W-1:0] word_index;
  logic [7:0]      high_byte_hold;
  logic [15:0]     running_crc;
  logic [7:0]      crc_low_hold;
  logic            wbank;
  logic [1:0]      busy;

  logic            acc;
  logic [15:0]     crc_upd;
  logic            count_bad;
  logic [WI_W-1:0] wi_inc;
  logic            low_done;
  logic            crc_match;

  always_comb begin
    // hold input while the target bank still feeds the output, or the queue is full
    s_tready  = !((phase == PH_LOW && busy[wbank]) || (phase == PH_CRC_HI && !desc_ready));
    acc       = s_tvalid && s_tready;
    crc_upd   = crc_feed((phase == PH_HUNT) ? CRC_INIT : running_crc, s_tdata);
    count_bad = s_tdata[0] || (s_tdata == 8'h00) || ({1'b0, s_tdata} > MaxBytes);
    wi_inc    = word_index + 1'b1;
    low_done  = 9'({wi_inc, 1'b0}) >= {1'b0, byte_count};
    crc_match = {s_tdata, crc_low_hold} == running_crc;

    wr.en      = acc && (phase == PH_LOW);
    wr.data    = {high_byte_hold, s_tdata};
    wr_addr    = {wbank, word_index[IDX_W-1:0]};
    desc_valid = acc && (phase == PH_CRC_HI) && crc_match;
    desc.bank  = wbank;
    desc.count = CNT_W'(word_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      byte_count     <= '0;
      word_index     <= '0;
      high_byte_hold <= '0;
      running_crc    <= CRC_INIT;
      crc_low_hold   <= '0;
      wbank          <= 1'b0;
      busy           <= '0;
    end else begin
      if (rel.valid) begin
        busy[rel.bank] <= 1'b0;
      end
      if (desc_valid) begin
        busy[wbank] <= 1'b1;
        wbank       <= ~wbank;
      end
      if (acc) begin
        unique case (phase)
          PH_HUNT: begin
            if (s_tdata == slave_address) begin
              running_crc <= crc_upd;
              phase       <= PH_FUNC;
            end
          end
          PH_FUNC: begin
            if (s_tdata == FUNC_READ_HOLDING) begin
              running_crc <= crc_upd;
              phase       <= PH_COUNT;
            end else begin
              running_crc <= CRC_INIT;
              phase       <= PH_HUNT;
            end
          end
          PH_COUNT: begin
            if (count_bad) begin
              running_crc <= CRC_INIT;
              phase       <= PH_HUNT;
            end else begin
              running_crc <= crc_upd;
              byte_count  <= s_tdata;
              word_index  <= '0;
              phase       <= PH_HIGH;
            end
          end
          PH_HIGH: begin
            running_crc    <= crc_upd;
            high_byte_hold <= s_tdata;
            phase          <= PH_LOW;
          end
          PH_LOW: begin
            running_crc <= crc_upd;
            word_index  <= wi_inc;
            phase       <= low_done ? PH_CRC_LO : PH_HIGH;
          end
          PH_CRC_LO: begin
            crc_low_hold <= s_tdata;
            phase        <= PH_CRC_HI;
          end
          PH_CRC_HI: begin
            running_crc <= CRC_INIT;
            phase       <= PH_HUNT;
          end
          default: begin
            running_crc <= CRC_INIT;
            phase       <= PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

// ----- design/mrp_queue.sv -----
// Two-entry queue of accepted-frame descriptors between parser and emitter.
module mrp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mrp_pkg::frame_desc_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mrp_pkg::frame_desc_t out_data
);
  import mrp_pkg::*;

  frame_desc_t entries [2];
  logic        wp;
  logic        rp;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  always_comb begin
    in_ready  = (fill != 2'd2);
    out_valid = (fill != 2'd0);
    out_data  = entries[rp];
    push      = in_valid && in_ready;
    pop       = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- design/mrp_back.sv -----
// Register store and emitter: streams the words of each accepted frame.
module mrp_back #(
  parameter int MAX_REGS = 8,
  parameter int IDX_W    = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mrp_pkg::store_wr_t   wr,
  input  logic [IDX_W:0]       wr_addr,
  input  logic                 hd_valid,
  output logic                 hd_ready,
  input  mrp_pkg::frame_desc_t hd,
  output mrp_pkg::release_t    rel,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // reg_index[2:0], reg_value[18:3], zero pad
  output logic                 m_tlast
);
  import mrp_pkg::*;

  localparam int DEPTH = 2 ** (IDX_W + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SHOW} state_t;

  logic [15:0]      store [DEPTH];
  logic [15:0]      rd_data;
  logic [IDX_W-1:0] cursor;
  state_t           state;
  logic             last;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr_addr] <= wr.data;
    end
    rd_data <= store[{hd.bank, cursor}];
  end

  always_comb begin
    last      = (CNT_W'(cursor) + 1'b1) == hd.count;
    m_tvalid  = (state == S_SHOW);
    m_tdata   = {5'b00000, rd_data, 3'(cursor)};
    m_tlast   = last;
    hd_ready  = m_tvalid && m_tready && last;
    rel.valid = hd_ready;
    rel.bank  = hd.bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (hd_valid) begin
            cursor <= '0;
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (m_tready) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              cursor <= cursor + 1'b1;
              state  <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_show_has_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> hd_valid)
    else $error("result shown with no frame queued");

  a_no_write_to_live_bank: assert property (@(posedge clk) disable iff (rst)
    (wr.en && state != S_IDLE) |-> (wr_addr[IDX_W] != hd.bank))
    else $error("store write into the bank being emitted");

  a_frame_count_range: assert property (@(posedge clk) disable iff (rst)
    hd_valid |-> ((hd.count != '0) && (hd.count <= CNT_W'(MAX_REGS))))
    else $error("queued frame with a register count out of range");

endmodule

// ----- design/modbus_read_response_parser.sv -----
// With the output side idle, a good frame's first register is offered once its descriptor
// has passed the frame queue and the emitter's store read and show states.
// Throughput: one byte per cycle in when not stalled; each register out is read, then shown.
// Input stalls while a frame's words target a bank still being emitted, or the queue is full.
// Two store banks and a two-deep frame queue let parsing and emission overlap.
// Reset (rst, synchronous): parser hunts for the address, CRC 0xFFFF, queue empty,
// slave address 0x0A; the register store is not cleared.
module modbus_read_response_parser #(
  parameter int MAX_REGS = mrp_pkg::MAX_REGS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // slave_address[7:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,       // reg_index[2:0], reg_value[18:3], zero pad
  output logic        m_tlast
);
  import mrp_pkg::*;

  localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  logic [7:0]      slave_address;
  store_wr_t       wr;
  logic [IDX_W:0]  wr_addr;
  logic            desc_valid;
  logic            desc_ready;
  frame_desc_t     desc;
  logic            hd_valid;
  logic            hd_ready;
  frame_desc_t     hd;
  release_t        rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDR_RESET;
    end else if (cfg_wr_en) begin
      slave_address <= cfg_wr_data;
    end
  end

  mrp_front #(
    .MAX_REGS (MAX_REGS),
    .IDX_W    (IDX_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .wr            (wr),
    .wr_addr       (wr_addr),
    .desc_valid    (desc_valid),
    .desc_ready    (desc_ready),
    .desc          (desc),
    .rel           (rel)
  );

  mrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (desc_valid),
    .in_ready  (desc_ready),
    .in_data   (desc),
    .out_valid (hd_valid),
    .out_ready (hd_ready),
    .out_data  (hd)
  );

  mrp_back #(
    .MAX_REGS (MAX_REGS),
    .IDX_W    (IDX_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .hd_valid (hd_valid),
    .hd_ready (hd_ready),
    .hd       (hd),
    .rel      (rel),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- dv/mrp_tb_pkg.sv -----
// Frame scoreboard for the Modbus read-response parser bench: parse tracking and register checks.
`timescale 1ns / 1ps
package mrp_tb_pkg;
  import mrp_pkg::*;

  localparam int REG_SLOTS = MAX_REGS_DEFAULT;

  typedef enum logic [2:0] {
    HUNT_ADDR,
    WANT_FUNC,
    WANT_COUNT,
    WORD_HI,
    WORD_LO,
    CRC_LO,
    CRC_HI
  } parse_state_e;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
    logic        last;
  } reg_result_t;

  class register_scoreboard;
    logic [7:0]   address;
    parse_state_e state;
    logic [4:0]   count_bytes;
    logic [3:0]   words_seen;
    logic [7:0]   hi_byte;
    logic [15:0]  crc;
    logic [7:0]   crc_lo;
    logic [15:0]  held_words [REG_SLOTS];
    reg_result_t  pending_regs [$];
    int           errors;

    function new();
      address = SLAVE_ADDR_RESET;
      state = HUNT_ADDR;
      count_bytes = '0;
      words_seen = '0;
      hi_byte = '0;
      crc = CRC_INIT;
      crc_lo = '0;
      errors = 0;
    endfunction

    static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
      return r;
    endfunction

    function void set_address(logic [7:0] a);
      address = a;
    endfunction

    // Advance the parse by one accepted byte; queue registers of a good frame
    function void note_byte(logic [7:0] b);
      reg_result_t r;
      int cnt;
      case (state)
        HUNT_ADDR: begin
          if (b == address) begin
            crc = crc16_step(CRC_INIT, b);
            state = WANT_FUNC;
          end
        end
        WANT_FUNC: begin
          if (b == FUNC_READ_HOLDING) begin
            crc = crc16_step(crc, b);
            state = WANT_COUNT;
          end else begin
            state = HUNT_ADDR;
            crc = CRC_INIT;
          end
        end
        WANT_COUNT: begin
          if (b[0] || b == 8'd0 || int'(b) > 2 * REG_SLOTS) begin
            state = HUNT_ADDR;
            crc = CRC_INIT;
          end else begin
            crc = crc16_step(crc, b);
            count_bytes = b[4:0];
            words_seen = '0;
            state = WORD_HI;
          end
        end
        WORD_HI: begin
          crc = crc16_step(crc, b);
          hi_byte = b;
          state = WORD_LO;
        end
        WORD_LO: begin
          crc = crc16_step(crc, b);
          if (int'(words_seen) < REG_SLOTS) begin
            held_words[words_seen[2:0]] = {hi_byte, b};
            words_seen = words_seen + 4'd1;
          end
          state = (int'(words_seen) * 2 >= int'(count_bytes)) ? CRC_LO : WORD_HI;
        end
        CRC_LO: begin
          crc_lo = b;
          state = CRC_HI;
        end
        CRC_HI: begin
          if ({b, crc_lo} == crc) begin
            cnt = (int'(words_seen) > REG_SLOTS) ? REG_SLOTS : int'(words_seen);
            for (int i = 0; i < cnt; i++) begin
              r.index = i[2:0];
              r.value = held_words[i[2:0]];
              r.last = (i == cnt - 1);
              pending_regs.push_back(r);
            end
          end
          state = HUNT_ADDR;
          crc = CRC_INIT;
        end
        default: begin
          state = HUNT_ADDR;
          crc = CRC_INIT;
        end
      endcase
    endfunction

    function void check_register(logic [2:0] index, logic [15:0] value, logic last);
      reg_result_t e;
      if (pending_regs.size() == 0) begin
        $error("register with nothing expected: reg_index %0d, reg_value %0d, last %0d",
               index, $signed(value), last);
        errors++;
        return;
      end
      e = pending_regs.pop_front();
      if (index !== e.index) begin
        $error("reg_index mismatch: expected %0d, actual %0d", e.index, index);
        errors++;
      end
      if (value !== e.value) begin
        $error("reg_value mismatch: expected %0d, actual %0d", $signed(e.value), $signed(value));
        errors++;
      end
      if (last !== e.last) begin
        $error("last mismatch: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_regs.size();
    endfunction
  endclass

endpackage

// ----- dv/tb_modbus_read_response_parser.sv -----
// Top-level bench for the Modbus read-response parser: frame stimulus, idling and checks.
`timescale 1ns / 1ps
module tb_modbus_read_response_parser;
  import mrp_pkg::*;
  import mrp_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 24;
  localparam int PHASE_BYTES = 20;

  typedef enum int {BAD_FUNC, ZERO_COUNT, ODD_COUNT, LONG_COUNT} header_fault_e;

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata     = 8'h00;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  logic        hold_req    = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          sent_count    = 0;
  int          hold_left     = 0;
  int          cycles        = 0;

  register_scoreboard sb = new();

  modbus_read_response_parser dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: check each item taken, then pick next ready (long hold on request)
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_register(m_tdata[2:0], m_tdata[18:3], m_tlast);
    if (hold_req) hold_left = LONG_HOLD;
    else if (hold_left > 0) hold_left--;
    m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Leave tvalid up after a handshake; the next call either keeps or drops it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    sent_count++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // fixed_word < 0 picks random register words
  task automatic send_frame(input int nregs, input bit bad_crc, input int fixed_word);
    logic [7:0]  frame_bytes [$];
    logic [15:0] crc;
    logic [15:0] w;
    frame_bytes.push_back(sb.address);
    frame_bytes.push_back(FUNC_READ_HOLDING);
    frame_bytes.push_back(8'(2 * nregs));
    for (int i = 0; i < nregs; i++) begin
      w = (fixed_word < 0) ? pick_word() : fixed_word[15:0];
      frame_bytes.push_back(w[15:8]);
      frame_bytes.push_back(w[7:0]);
    end
    crc = CRC_INIT;
    foreach (frame_bytes[i]) crc = register_scoreboard::crc16_step(crc, frame_bytes[i]);
    if (bad_crc) crc ^= 16'h0001 << $urandom_range(15);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic send_bad_header(input header_fault_e fault);
    logic [7:0] f;
    send_byte(sb.address);
    case (fault)
      BAD_FUNC: begin
        do f = 8'($urandom_range(255)); while (f == FUNC_READ_HOLDING);
        send_byte(f);
      end
      ZERO_COUNT: begin
        send_byte(FUNC_READ_HOLDING);
        send_byte(8'd0);
      end
      ODD_COUNT: begin
        send_byte(FUNC_READ_HOLDING);
        send_byte(8'(2 * $urandom_range(127) + 1));
      end
      default: begin
        send_byte(FUNC_READ_HOLDING);
        send_byte(8'(2 * $urandom_range(REG_SLOTS + 1, 127)));
      end
    endcase
  endtask

  task automatic run_random(input int budget);
    int start;
    int pick;
    start = sent_count;
    while (sent_count - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 65) send_frame($urandom_range(1, REG_SLOTS), 1'b0, -1);
      else if (pick < 77) send_frame($urandom_range(1, REG_SLOTS), 1'b1, -1);
      else if (pick < 90) send_bad_header(header_fault_e'($urandom_range(3)));
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
    end
  endtask

  // Drop tvalid, wait out every expected register, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_address(a);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: wrong address, address as function code, good frame, bad counts, bad CRC
    send_byte(sb.address + 8'd1);
    send_byte(sb.address);
    send_byte(sb.address);
    send_frame(1, 1'b0, 16'h8000);
    send_byte(sb.address);
    send_byte(FUNC_READ_HOLDING);
    send_byte(8'd0);
    send_byte(sb.address);
    send_byte(FUNC_READ_HOLDING);
    send_byte(8'd5);
    send_byte(sb.address);
    send_byte(FUNC_READ_HOLDING);
    send_byte(8'(2 * REG_SLOTS + 2));
    send_frame(1, 1'b1, 16'h7FFF);
    drain();

    // Hold the receiver off while full-size frames stream in at full rate
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (4) send_frame(REG_SLOTS, 1'b0, -1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      case (ph)
        0: write_address(8'h00);
        1: write_address(8'hFF);
        2: write_address(8'($urandom_range(1, 254)));
        default: write_address(SLAVE_ADDR_RESET);
      endcase
      run_random(PHASE_BYTES);
      drain();
    end

    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
